/* rtl/fts_pkg.sv */
// shared types and constants for the frequency table statistics unit
package fts_pkg;
  localparam int MaxRowsDefault = 256;
  localparam int ValueW = 32;
  localparam int FreqW = 16;
  localparam int CountW = 24;
  localparam int StatW = 4;

  localparam logic [StatW-1:0] StatMean   = 4'd0;
  localparam logic [StatW-1:0] StatPopSd  = 4'd1;
  localparam logic [StatW-1:0] StatSampSd = 4'd2;
  localparam logic [StatW-1:0] StatMax    = 4'd3;
  localparam logic [StatW-1:0] StatMin    = 4'd4;
  localparam logic [StatW-1:0] StatRange  = 4'd5;
  localparam logic [StatW-1:0] StatMedian = 4'd6;
  localparam logic [StatW-1:0] StatQ1     = 4'd7;
  localparam logic [StatW-1:0] StatQ3     = 4'd8;

  localparam logic signed [63:0] SatMax = 64'sd2147483647;
  localparam logic signed [63:0] SatMin = -64'sd2147483648;

  // input word: one table row
  typedef struct packed {
    logic signed [ValueW-1:0] row_value;
    logic [FreqW-1:0]         row_frequency;
    logic                     last_row;
  } row_word_t;

  // output word: one statistic
  typedef struct packed {
    logic [StatW-1:0]         statistic;
    logic signed [ValueW-1:0] stat_value;
    logic                     valid_res;
    logic                     last_result;
  } stat_word_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [ValueW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > SatMax) t = SatMax;
    if (v < SatMin) t = SatMin;
    return t[ValueW-1:0];
  endfunction
endpackage

/* rtl/fts_if.sv */
// valid/ready channel carrying one word
interface fts_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/frequency_table_statistics_unit.sv */
// frequency table statistics unit: rows load one per cycle, nine results per table
// after the last row it runs: squared deviations per row, an insertion sort, three
// divisions, two roots, six count walks over the sorted rows, then the results in turn
// throughput: one row per cycle while loading; not ready from last row to ninth result
// reset: synchronous; clears counters and sums, the row store is not cleared
module frequency_table_statistics_unit
  import fts_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDefault
) (
  input logic clk,
  input logic rst,
  fts_if.sink   in_ch,
  fts_if.source out_ch
);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_MEAN, S_MEAN_W, S_SQ_RD, S_SQ_WAIT, S_SQ_MUL, S_SQ_ACC, S_SQ_HI,
    S_SORT_I, S_SORT_KEY, S_SORT_RD, S_SORT_WAIT, S_SORT_CMP, S_SORT_PUT,
    S_DEV_DIV, S_DEV_DW, S_DEV_SQ, S_DEV_SW,
    S_EXT_RD, S_EXT_W, S_KTH_RD, S_KTH_W, S_KTH_CHK, S_OUT
  } state_t;

  state_t state;

  // row store
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [ValueW-1:0] ram_wv, ram_rv;
  logic [FreqW-1:0]  ram_wc, ram_rc;

  fts_ram #(.Width(ValueW), .Depth(MAX_ROWS)) u_vals (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wv), .rdata(ram_rv));
  fts_ram #(.Width(FreqW), .Depth(MAX_ROWS)) u_cnts (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wc), .rdata(ram_rc));

  // shared divider and root
  logic         div_start, div_busy;
  logic [127:0] div_num, div_quo;
  logic [63:0]  div_den;
  logic         sq_start, sq_busy;
  logic [63:0]  sq_val;
  logic [31:0]  sq_root;

  fts_divider u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(div_den), .busy(div_busy), .quo(div_quo));
  fts_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .val(sq_val),
    .busy(sq_busy), .root(sq_root));

  logic [RW-1:0]     rows;
  logic [CountW-1:0] total;
  logic signed [63:0] wsum;
  logic [127:0]       sqsum;
  logic signed [ValueW-1:0] mean, mx, mn;
  logic [RW-1:0]     idx, jdx;
  logic signed [ValueW-1:0] key_v;
  logic [FreqW-1:0]  key_c;
  logic [63:0]       sq;
  logic [47:0]       sq_part;
  logic [1:0]        dev_sel;
  logic [31:0]       dev_pop, dev_samp;
  logic              dev_sat;
  // order statistics jobs
  logic [2:0]        job;
  logic [CountW-1:0] kpos;
  logic [CountW-1:0] acc;
  logic signed [ValueW-1:0] kv [6];
  logic [CountW-1:0] half;
  logic [3:0]        ocnt;
  logic              sort_write;
  logic [2:0]        jsel, jsel_hi;

  logic signed [32:0] dfull;
  assign dfull = $signed({ram_rv[31], ram_rv}) - $signed({mean[31], mean});

  // target element index for each median job
  function automatic logic [CountW-1:0] kidx(input logic [2:0] j,
      input logic [CountW-1:0] n, input logic [CountW-1:0] h);
    logic [CountW-1:0] off, len;
    off = '0;
    len = n;
    if (j >= 3'd2 && j < 3'd4) len = h;
    if (j >= 3'd4) begin
      off = n - h;
      len = h;
    end
    if (len[0]) return off + ((len - 1'b1) >> 1);
    if (!j[0]) return off + (len >> 1) - 1'b1;
    return off + (len >> 1);
  endfunction

  assign kpos = kidx(job, total, half);

  // 33 bit unsigned magnitude of the signed deviation, used for squared deviations
  logic [32:0] dabs;
  assign dabs = dfull[32] ? 33'(-dfull) : 33'(dfull);

  // low or high half of the square times the row count
  assign sq_part = ((state == S_SQ_HI) ? sq[63:32] : sq[31:0]) * ram_rc;

  assign in_ch.ready = (state == S_LOAD);
  assign div_den = (dev_sel == 2'd0) ? 64'(total)
                 : (dev_sel == 2'd1) ? 64'(total) : 64'(total - 1'b1);

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx[AW-1:0];
    ram_wv = in_ch.data.row_value;
    ram_wc = in_ch.data.row_frequency;
    if (state == S_LOAD) begin
      ram_addr = rows[AW-1:0];
      ram_we = in_ch.valid && in_ch.data.row_frequency != '0
               && rows < RW'(MAX_ROWS);
    end else if (state == S_SORT_RD || state == S_SORT_WAIT) begin
      ram_addr = jdx[AW-1:0] - 1'b1;
    end else if (state == S_SORT_PUT || state == S_SORT_CMP) begin
      ram_addr = jdx[AW-1:0];
      ram_we = sort_write;
      ram_wv = key_v;
      ram_wc = key_c;
      if (state == S_SORT_CMP) begin
        ram_wv = ram_rv;
        ram_wc = ram_rc;
      end
    end else if (state == S_EXT_RD || state == S_EXT_W) begin
      ram_addr = (jdx == '0) ? '0 : AW'(rows - 1'b1);
    end
  end

  always_comb begin
    sort_write = 1'b0;
    if (state == S_SORT_CMP) sort_write = (jdx != '0) && $signed(ram_rv) > key_v;
    if (state == S_SORT_PUT) sort_write = 1'b1;
  end

  // first job slot of each median result
  function automatic logic [2:0] job_o(input logic [3:0] o);
    if (o == StatMedian) return 3'd0;
    if (o == StatQ1) return 3'd2;
    return 3'd4;
  endfunction

  assign jsel = job_o(ocnt);
  assign jsel_hi = jsel + 3'd1;

  logic signed [63:0] out_v;
  logic signed [32:0] pair;
  assign pair = ($signed({kv[jsel][31], kv[jsel]})
               + $signed({kv[jsel_hi][31], kv[jsel_hi]}));

  // value of each result
  logic par_odd;
  always_comb begin
    out_v = '0;
    par_odd = 1'b0;
    case (ocnt)
      StatMean:   out_v = 64'(mean);
      StatPopSd:  out_v = dev_sat && dev_pop[31] ? SatMax : {32'd0, dev_pop};
      StatSampSd: out_v = {32'd0, dev_samp};
      StatMax:    out_v = 64'(mx);
      StatMin:    out_v = 64'(mn);
      StatRange:  out_v = 64'(mx) - 64'(mn);
      default: begin
        if (ocnt == StatMedian) par_odd = total[0];
        else par_odd = half[0];
        if (par_odd) out_v = 64'(kv[jsel]);
        else begin
          out_v = 64'(pair >>> 1);
          if (pair[32] && pair[0]) out_v = out_v + 64'sd1;
        end
      end
    endcase
  end

  logic ok;
  assign ok = (total != '0) && (ocnt != StatSampSd || total > CountW'(1));
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.statistic = ocnt;
  assign out_ch.data.stat_value = ok ? sat32(out_v) : '0;
  assign out_ch.data.valid_res = ok;
  assign out_ch.data.last_result = (ocnt == StatQ3);

  logic signed [63:0] wabs;
  assign wabs = wsum[63] ? -wsum : wsum;

  logic [127:0] q_sel;
  assign q_sel = div_quo;
  assign div_num = (dev_sel == 2'd0) ? {64'd0, wabs} : sqsum;
  assign sq_val = q_sel[63:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      rows  <= '0;
      total <= '0;
      wsum  <= '0;
      sqsum <= '0;
      dev_sat <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_ch.valid) begin
            if (ram_we) begin
              rows  <= rows + 1'b1;
              total <= total + CountW'(in_ch.data.row_frequency);
              wsum  <= wsum + 64'($signed(in_ch.data.row_value))
                       * $signed({1'b0, in_ch.data.row_frequency});
            end
            if (in_ch.data.last_row) state <= S_MEAN;
          end
        end
        S_MEAN: begin
          dev_sel <= 2'd0;
          if (total == '0) begin
            mean <= '0;
            state <= S_OUT;
            ocnt <= '0;
          end else begin
            div_start <= 1'b1;
            state <= S_MEAN_W;
          end
        end
        S_MEAN_W: begin
          if (!div_busy && !div_start) begin
            // signed truncating quotient from magnitude division
            mean <= wsum[63] ? -div_quo[31:0] : div_quo[31:0];
            state <= S_SQ_RD;
            idx <= '0;
          end
        end
        S_SQ_RD: begin
          if (idx == rows) begin
            state <= S_SORT_I;
            idx <= RW'(1);
          end else state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: state <= S_SQ_MUL;
        S_SQ_MUL: begin
          sq <= dabs[31:0] * dabs[31:0];
          state <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          sqsum <= sqsum + 128'(sq_part);
          state <= S_SQ_HI;
        end
        S_SQ_HI: begin
          sqsum <= sqsum + {48'd0, sq_part, 32'd0};
          idx <= idx + 1'b1;
          state <= S_SQ_RD;
        end
        S_SORT_I: begin
          if (idx >= rows) begin
            state <= S_DEV_DIV;
            dev_sel <= 2'd1;
          end else begin
            jdx <= idx;
            state <= S_SORT_KEY;
          end
        end
        S_SORT_KEY: begin
          key_v <= $signed(ram_rv);
          key_c <= ram_rc;
          state <= S_SORT_RD;
        end
        S_SORT_RD: state <= S_SORT_WAIT;
        S_SORT_WAIT: begin
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (sort_write) begin
            jdx <= jdx - 1'b1;
            state <= S_SORT_RD;
          end else state <= S_SORT_PUT;
        end
        S_SORT_PUT: begin
          idx <= idx + 1'b1;
          state <= S_SORT_I;
        end
        S_DEV_DIV: begin
          if (dev_sel == 2'd2 && total <= CountW'(1)) begin
            dev_samp <= '0;
            state <= S_EXT_RD;
            jdx <= '0;
          end else begin
            div_start <= 1'b1;
            state <= S_DEV_DW;
          end
        end
        S_DEV_DW: begin
          if (!div_busy && !div_start) begin
            if (div_quo[127:62] != '0) begin
              if (dev_sel == 2'd1) dev_pop <= 32'h7FFF_FFFF;
              else dev_samp <= 32'h7FFF_FFFF;
              dev_sat <= 1'b1;
              state <= S_DEV_SW;
            end else begin
              sq_start <= 1'b1;
              state <= S_DEV_SQ;
            end
          end
        end
        S_DEV_SQ: state <= S_DEV_SW;
        S_DEV_SW: begin
          if (!sq_busy) begin
            if (div_quo[127:62] == '0) begin
              if (dev_sel == 2'd1) dev_pop <= sq_root;
              else dev_samp <= sq_root;
            end
            if (dev_sel == 2'd1) begin
              dev_sel <= 2'd2;
              state <= S_DEV_DIV;
            end else begin
              jdx <= '0;
              state <= S_EXT_RD;
            end
          end
        end
        S_EXT_RD: state <= S_EXT_W;
        S_EXT_W: begin
          if (jdx == '0) begin
            mn <= ram_rv;
            jdx <= RW'(1);
            state <= S_EXT_RD;
          end else begin
            mx <= ram_rv;
            half <= (total + 1'b1) >> 1;
            job <= '0;
            state <= S_KTH_RD;
            idx <= '0;
            acc <= '0;
          end
        end
        S_KTH_RD: state <= S_KTH_W;
        S_KTH_W: state <= S_KTH_CHK;
        S_KTH_CHK: begin
          if (kpos < acc + CountW'(ram_rc) || idx + 1'b1 >= rows) begin
            kv[job] <= ram_rv;
            idx <= '0;
            acc <= '0;
            if (job == 3'd5) begin
              state <= S_OUT;
              ocnt <= '0;
            end else begin
              job <= job + 1'b1;
              state <= S_KTH_RD;
            end
          end else begin
            acc <= acc + CountW'(ram_rc);
            idx <= idx + 1'b1;
            state <= S_KTH_RD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ocnt <= ocnt + 1'b1;
            if (ocnt == StatQ3) begin
              state <= S_LOAD;
              rows <= '0;
              total <= '0;
              wsum <= '0;
              sqsum <= '0;
              dev_sat <= 1'b0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

/* rtl/fts_ram.sv */
// generic single port ram with registered read
module fts_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // registered read, old contents returned on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/fts_divider.sv */
// restoring divider, one quotient bit per cycle, shared for all divisions
module fts_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic [127:0] quo
);
  logic [127:0] n;
  logic [64:0]  rem;
  logic [7:0]   cnt;
  logic [64:0]  trial;

  assign trial = {rem[63:0], n[127]};

  // one shift and compare per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 8'd127;
      n    <= num;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      n <= {n[126:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[126:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[126:0], 1'b0};
      end
      if (cnt == 8'd0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 8'd1;
    end
  end
endmodule

/* rtl/fts_sqrt.sv */
// bit pair square root, one result bit per cycle
module fts_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [64:0] sum;

  assign sum = {1'b0, res} + {1'b0, bitv};
  assign root = res[31:0];

  // one step of the digit recurrence per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      v    <= val;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if ({1'b0, v} >= sum) begin
        v   <= v - sum[63:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0] || bitv == 64'd0) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
